// ----- design/bge_pkg.sv -----
// Shared types and constants for the bilinear grid elevation block.
// Holds the grid geometry, field widths, register indexes and the queue item type.
// No dependencies; every other design file imports this package.
`default_nettype none

package bge_pkg;

   // Grid geometry and cell width.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int ELEV_BITS  = 16;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int WDIM_BITS = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;

   // Fixed field widths of the channels.
   localparam int CELL_IN_BITS = 8;
   localparam int ELEV_IN_BITS = 16;
   localparam int POS_BITS     = 32;
   localparam int OUT_BITS     = 24;
   localparam int FRAC_BITS    = 16;
   localparam int SCALE_BITS   = 32;
   localparam int DIM_CFG_BITS = 9;
   localparam int PROD_BITS    = POS_BITS + SCALE_BITS;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HAS_ELEVATION = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH    = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT   = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CELLS_PER_FT  = 8'd3;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [ELEV_BITS-1:0] elev_type;

   // One classified item. A write uses x0 and r0 as its cell and elev as its data.
   typedef struct packed {
      logic                 is_query;
      logic                 zero;
      logic [COL_BITS-1:0]  x0;
      logic [COL_BITS-1:0]  x1;
      logic [ROW_BITS-1:0]  r0;
      logic [ROW_BITS-1:0]  r1;
      logic [FRAC_BITS-1:0] tx;
      logic [FRAC_BITS-1:0] ty;
      elev_type             elev;
   } item_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- design/bge_if.sv -----
// Channel interfaces of the bilinear grid elevation block: request, response, CSR.
// Each carries valid, ready and its payload; a transfer happens when both are high.
// Depends on bge_pkg for the field widths.
`default_nettype none

interface bge_req_if;
   import bge_pkg::*;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic        [CELL_IN_BITS-1:0] cell_col;
   logic        [CELL_IN_BITS-1:0] cell_row;
   logic signed [ELEV_IN_BITS-1:0] cell_elev;
   logic signed [POS_BITS-1:0]     east_ft;
   logic signed [POS_BITS-1:0]     northing_ft;

   modport source (output valid, cmd, cell_col, cell_row, cell_elev, east_ft, northing_ft,
                   input ready);
   modport sink (input valid, cmd, cell_col, cell_row, cell_elev, east_ft, northing_ft,
                 output ready);
endinterface

interface bge_rsp_if;
   import bge_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] elevation_q8;

   modport source (output valid, elevation_q8, input ready);
   modport sink (input valid, elevation_q8, output ready);
endinterface

interface bge_csr_if;
   import bge_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/bilinear_grid_elevation.sv -----
// Bilinear grid elevation: a query passes through the front's stage-1 registers, the item
// queue, the four corner reads, the blend stages and the response queue.
// A query waits until the previous one has issued its four reads on the single grid
// RAM port; cell writes sustain one per cycle while no query is reading the grid.
// Synchronous reset clears the control state and sets the registers to their reset
// values; grid cells hold no defined value until written, and no clearing pass runs.
`default_nettype none

module bilinear_grid_elevation (
   input  wire logic clock,
   input  wire logic reset,
   bge_req_if.sink   req_if,
   bge_rsp_if.source rsp_if,
   bge_csr_if.sink   csr_if
);
   import bge_pkg::*;

   logic             push_valid;
   item_type         push_item;
   logic             pop;
   item_type         head_item;
   queue_status_type queue_status;

   // Intake, scaling and clamping.
   bge_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .csr_if       (csr_if),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   // Decoupling queue.
   bge_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .status     (queue_status)
   );

   // Grid storage, corner reads and blending.
   bge_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_if       (rsp_if)
   );

endmodule

`default_nettype wire

// ----- design/bge_front.sv -----
// Front part: configuration registers, request intake, position scaling and clamping.
// Turns each request into a classified item for the queue.
// Depends on bge_pkg and the channel interfaces in bge_if.sv.
`default_nettype none

module bge_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bge_req_if.sink                        req_if,
   bge_csr_if.sink                        csr_if,
   input  wire bge_pkg::queue_status_type queue_status,
   output logic                           push_valid,
   output bge_pkg::item_type              push_item
);
   import bge_pkg::*;

   localparam int CX_BITS = PROD_BITS - FRAC_BITS;

   logic                    has_elev_ff, has_elev_in;
   logic [DIM_CFG_BITS-1:0] grid_width_ff, grid_width_in;
   logic [DIM_CFG_BITS-1:0] grid_height_ff, grid_height_in;
   logic [SCALE_BITS-1:0]   cpf_ff, cpf_in;

   logic                           req_xfer;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_query_ff, s1_query_in;
   logic        [CELL_IN_BITS-1:0] s1_col_ff, s1_col_in;
   logic        [CELL_IN_BITS-1:0] s1_row_ff, s1_row_in;
   logic signed [ELEV_IN_BITS-1:0] s1_elev_ff, s1_elev_in;
   logic                           s1_xneg_ff, s1_xneg_in;
   logic                           s1_yneg_ff, s1_yneg_in;
   logic        [PROD_BITS-1:0]    s1_px_ff, s1_px_in;
   logic        [PROD_BITS-1:0]    s1_py_ff, s1_py_in;

   logic [WDIM_BITS-1:0] width_eff;
   logic [HDIM_BITS-1:0] height_eff;
   logic [CX_BITS-1:0]   cx_limit, cy_limit, cx, cy;
   logic [COL_BITS-1:0]  x0, x1;
   logic [ROW_BITS-1:0]  y0, y1;
   logic                 in_grid;

   // Register writes are always taken.
   assign csr_if.ready = 1'b1;

   always_comb begin
      has_elev_in    = has_elev_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      cpf_in         = cpf_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_HAS_ELEVATION: has_elev_in    = csr_if.data[0];
            CSR_GRID_WIDTH:    grid_width_in  = csr_if.data[DIM_CFG_BITS-1:0];
            CSR_GRID_HEIGHT:   grid_height_in = csr_if.data[DIM_CFG_BITS-1:0];
            CSR_CELLS_PER_FT:  cpf_in         = csr_if.data[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_elev_ff    <= 1'b0;
         grid_width_ff  <= DIM_CFG_BITS'(256);
         grid_height_ff <= DIM_CFG_BITS'(256);
         cpf_ff         <= '0;
      end else begin
         has_elev_ff    <= has_elev_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         cpf_ff         <= cpf_in;
      end
   end

   // A request is taken only when the queue can hold it along with the item in stage 1.
   assign req_if.ready = ({1'b0, queue_status.count} + {{QCNT_BITS{1'b0}}, s1_valid_ff})
                         < (QCNT_BITS + 1)'(QUEUE_DEPTH);
   assign req_xfer = req_if.valid && req_if.ready;

   // Stage 1: scale both positions by the cells-per-foot register.
   always_comb begin
      s1_valid_in = req_xfer;
      s1_query_in = (req_if.cmd == CMD_QUERY);
      s1_col_in   = req_if.cell_col;
      s1_row_in   = req_if.cell_row;
      s1_elev_in  = req_if.cell_elev;
      s1_xneg_in  = req_if.east_ft[POS_BITS-1];
      s1_yneg_in  = req_if.northing_ft[POS_BITS-1];
      s1_px_in    = PROD_BITS'($unsigned(req_if.east_ft)) * PROD_BITS'(cpf_ff);
      s1_py_in    = PROD_BITS'($unsigned(req_if.northing_ft)) * PROD_BITS'(cpf_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_query_ff <= s1_query_in;
         s1_col_ff   <= s1_col_in;
         s1_row_ff   <= s1_row_in;
         s1_elev_ff  <= s1_elev_in;
         s1_xneg_ff  <= s1_xneg_in;
         s1_yneg_ff  <= s1_yneg_in;
         s1_px_ff    <= s1_px_in;
         s1_py_ff    <= s1_py_in;
      end
   end

   // Effective grid size: zero acts as one, anything above the stored grid saturates.
   always_comb begin
      if (grid_width_ff == '0) begin
         width_eff = WDIM_BITS'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         width_eff = WDIM_BITS'(MAX_WIDTH);
      end else begin
         width_eff = WDIM_BITS'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         height_eff = HDIM_BITS'(1);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         height_eff = HDIM_BITS'(MAX_HEIGHT);
      end else begin
         height_eff = HDIM_BITS'(grid_height_ff);
      end
   end

   // Clamp the cell coordinates and find the neighbour columns and rows.
   always_comb begin
      cx_limit = CX_BITS'(width_eff - WDIM_BITS'(1)) << FRAC_BITS;
      cy_limit = CX_BITS'(height_eff - HDIM_BITS'(1)) << FRAC_BITS;

      if (s1_xneg_ff) begin
         cx = '0;
      end else if (s1_px_ff[PROD_BITS-1:FRAC_BITS] > cx_limit) begin
         cx = cx_limit;
      end else begin
         cx = s1_px_ff[PROD_BITS-1:FRAC_BITS];
      end
      if (s1_yneg_ff) begin
         cy = '0;
      end else if (s1_py_ff[PROD_BITS-1:FRAC_BITS] > cy_limit) begin
         cy = cy_limit;
      end else begin
         cy = s1_py_ff[PROD_BITS-1:FRAC_BITS];
      end

      x0 = cx[FRAC_BITS +: COL_BITS];
      y0 = cy[FRAC_BITS +: ROW_BITS];
      if ((WDIM_BITS'(x0) + WDIM_BITS'(1)) < width_eff) begin
         x1 = x0 + COL_BITS'(1);
      end else begin
         x1 = COL_BITS'(width_eff - WDIM_BITS'(1));
      end
      if ((HDIM_BITS'(y0) + HDIM_BITS'(1)) < height_eff) begin
         y1 = y0 + ROW_BITS'(1);
      end else begin
         y1 = ROW_BITS'(height_eff - HDIM_BITS'(1));
      end
   end

   // Build the queue item. Writes outside the stored grid are dropped here.
   assign in_grid = (32'(s1_col_ff) < MAX_WIDTH) && (32'(s1_row_ff) < MAX_HEIGHT);

   always_comb begin
      push_item.is_query = s1_query_ff;
      push_item.zero     = !has_elev_ff || (cpf_ff == '0);
      push_item.tx       = cx[FRAC_BITS-1:0];
      push_item.ty       = cy[FRAC_BITS-1:0];
      push_item.x1       = x1;
      push_item.r1       = ROW_BITS'(height_eff - HDIM_BITS'(1) - HDIM_BITS'(y1));
      push_item.elev     = ELEV_BITS'(s1_elev_ff);
      if (s1_query_ff) begin
         push_item.x0 = x0;
         push_item.r0 = ROW_BITS'(height_eff - HDIM_BITS'(1) - HDIM_BITS'(y0));
      end else begin
         push_item.x0 = COL_BITS'(s1_col_ff);
         push_item.r0 = ROW_BITS'(s1_row_ff);
      end
   end

   assign push_valid = s1_valid_ff && (s1_query_ff || in_grid);

endmodule

`default_nettype wire

// ----- design/bge_queue.sv -----
// Short item queue between the front and the back of the elevation block.
// Lets each side stall on its own; reports its fill level as a status struct.
// Depends on bge_pkg for the item and status types.
`default_nettype none

module bge_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire bge_pkg::item_type push_item,
   input  wire logic              pop,
   output bge_pkg::item_type      head_item,
   output bge_pkg::queue_status_type status
);
   import bge_pkg::*;

   item_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item        = entries_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

endmodule

`default_nettype wire

// ----- design/bge_back.sv -----
// Back part: the elevation grid RAM, the four-read sequencer, the bilinear blend
// pipeline and the response queue. Depends on bge_pkg and bge_if.sv.
`default_nettype none

module bge_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bge_pkg::queue_status_type queue_status,
   input  wire bge_pkg::item_type         head_item,
   output logic                           pop,
   bge_rsp_if.source                      rsp_if
);
   import bge_pkg::*;

   // Corner read order of the sequencer.
   localparam logic [1:0] CORNER_00 = 2'd0;
   localparam logic [1:0] CORNER_10 = 2'd1;
   localparam logic [1:0] CORNER_01 = 2'd2;
   localparam logic [1:0] CORNER_11 = 2'd3;

   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OCNT_BITS   = $clog2(OUT_DEPTH + 1);
   localparam int DIFF1_BITS  = ELEV_BITS + 1;
   localparam int WGT_BITS    = FRAC_BITS + 1;
   localparam int P1_BITS     = DIFF1_BITS + WGT_BITS;
   localparam int E0_BITS     = ELEV_BITS + FRAC_BITS + 2;
   localparam int D2_BITS     = E0_BITS + 1;
   localparam int P2_BITS     = D2_BITS + WGT_BITS;
   localparam int E_BITS      = E0_BITS + FRAC_BITS + 2;
   localparam int ROUND_SHIFT = 2 * FRAC_BITS - 8;

   localparam logic signed [E_BITS-1:0] HALF_LSB = E_BITS'(1) <<< (ROUND_SHIFT - 1);
   localparam logic signed [E_BITS-1:0] OUT_MAX  = (E_BITS'(1) <<< (OUT_BITS - 1)) - E_BITS'(1);
   localparam logic signed [E_BITS-1:0] OUT_MIN  = -OUT_MAX - E_BITS'(1);

   elev_type             grid_mem [2**ADDR_BITS];
   logic [ADDR_BITS-1:0] mem_addr;
   logic                 mem_we;
   elev_type             rdata_ff;

   logic                 pop_query, credit_ok;
   logic                 busy_ff, busy_in;
   logic [1:0]           phase_ff, phase_in;
   item_type             cur_ff, cur_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [1:0]           rd_sel_ff, rd_sel_in;
   logic [OCNT_BITS-1:0] inflight_ff, inflight_in;

   elev_type e00_ff, e00_in, e10_ff, e10_in, e01_ff, e01_in;
   logic     launch;

   logic signed [DIFF1_BITS-1:0] d_top, d_bot;
   logic signed [WGT_BITS-1:0]   tx_s, ty_s;
   logic signed [P1_BITS-1:0]    p_top, p_bot;
   logic                         bl1_valid_ff, bl1_zero_ff, bl1_zero_in;
   logic [FRAC_BITS-1:0]         bl1_ty_ff, bl1_ty_in;
   logic signed [E0_BITS-1:0]    e0_ff, e0_in, e1_ff, e1_in;

   logic signed [D2_BITS-1:0] d_mid;
   logic signed [P2_BITS-1:0] p_mid;
   logic                      bl2_valid_ff, bl2_zero_ff, bl2_zero_in;
   logic signed [E_BITS-1:0]  e_ff, e_in;

   logic signed [E_BITS-1:0]   rounded, shifted;
   logic signed [OUT_BITS-1:0] result;

   logic signed [OUT_BITS-1:0] ofifo_ff [OUT_DEPTH];
   logic [OPTR_BITS-1:0]       ow_ptr_ff, ow_ptr_in, or_ptr_ff, or_ptr_in;
   logic [OCNT_BITS-1:0]       ocount_ff, ocount_in;
   logic                       rsp_xfer;

   // Take an item when idle; a query also needs a free response slot.
   assign credit_ok = inflight_ff < OCNT_BITS'(OUT_DEPTH);
   assign pop       = queue_status.not_empty && !busy_ff && (!head_item.is_query || credit_ok);
   assign pop_query = pop && head_item.is_query;
   assign mem_we    = pop && !head_item.is_query;
   assign rsp_xfer  = rsp_if.valid && rsp_if.ready;

   // Sequencer: one grid read per cycle, four per query.
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      if (pop_query) begin
         busy_in  = 1'b1;
         phase_in = CORNER_10;
         cur_in   = head_item;
      end else if (busy_ff) begin
         if (phase_ff == CORNER_11) begin
            busy_in = 1'b0;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
      rd_valid_in = pop_query || busy_ff;
      rd_sel_in   = busy_ff ? phase_ff : CORNER_00;
   end

   always_comb begin
      mem_addr = {head_item.r0, head_item.x0};
      if (busy_ff) begin
         case (phase_ff)
            CORNER_10: mem_addr = {cur_ff.r0, cur_ff.x1};
            CORNER_01: mem_addr = {cur_ff.r1, cur_ff.x0};
            CORNER_11: mem_addr = {cur_ff.r1, cur_ff.x1};
            default:   mem_addr = {cur_ff.r0, cur_ff.x0};
         endcase
      end
   end

   // Grid RAM: one port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_addr] <= head_item.elev;
      end
      rdata_ff <= grid_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         phase_ff    <= CORNER_00;
         rd_valid_ff <= 1'b0;
         rd_sel_ff   <= CORNER_00;
         inflight_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         phase_ff    <= phase_in;
         rd_valid_ff <= rd_valid_in;
         rd_sel_ff   <= rd_sel_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Queries started minus responses transferred.
   always_comb begin
      inflight_in = inflight_ff;
      if (pop_query && !rsp_xfer) begin
         inflight_in = inflight_ff + OCNT_BITS'(1);
      end else if (rsp_xfer && !pop_query) begin
         inflight_in = inflight_ff - OCNT_BITS'(1);
      end
   end

   // Collect the first three corners; the last one feeds the blend directly.
   always_comb begin
      e00_in = (rd_valid_ff && rd_sel_ff == CORNER_00) ? rdata_ff : e00_ff;
      e10_in = (rd_valid_ff && rd_sel_ff == CORNER_10) ? rdata_ff : e10_ff;
      e01_in = (rd_valid_ff && rd_sel_ff == CORNER_01) ? rdata_ff : e01_ff;
   end
   assign launch = rd_valid_ff && (rd_sel_ff == CORNER_11);

   always_ff @(posedge clock) begin
      e00_ff <= e00_in;
      e10_ff <= e10_in;
      e01_ff <= e01_in;
   end

   // Blend stage 1: interpolate along x for both rows, exact in Q.16.
   always_comb begin
      d_top       = DIFF1_BITS'(e10_ff) - DIFF1_BITS'(e00_ff);
      d_bot       = DIFF1_BITS'(rdata_ff) - DIFF1_BITS'(e01_ff);
      tx_s        = signed'({1'b0, cur_ff.tx});
      p_top       = d_top * tx_s;
      p_bot       = d_bot * tx_s;
      e0_in       = (E0_BITS'(e00_ff) <<< FRAC_BITS) + E0_BITS'(p_top);
      e1_in       = (E0_BITS'(e01_ff) <<< FRAC_BITS) + E0_BITS'(p_bot);
      bl1_ty_in   = cur_ff.ty;
      bl1_zero_in = cur_ff.zero;
   end

   // Blend stage 2: interpolate along y, exact in Q.32.
   always_comb begin
      ty_s        = signed'({1'b0, bl1_ty_ff});
      d_mid       = D2_BITS'(e1_ff) - D2_BITS'(e0_ff);
      p_mid       = d_mid * ty_s;
      e_in        = (E_BITS'(e0_ff) <<< FRAC_BITS) + E_BITS'(p_mid);
      bl2_zero_in = bl1_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bl1_valid_ff <= 1'b0;
         bl2_valid_ff <= 1'b0;
      end else begin
         bl1_valid_ff <= launch;
         bl2_valid_ff <= bl1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      bl1_ty_ff   <= bl1_ty_in;
      bl1_zero_ff <= bl1_zero_in;
      e_ff        <= e_in;
      bl2_zero_ff <= bl2_zero_in;
   end

   // Round half up to Q.8 and saturate to the response width.
   always_comb begin
      rounded = e_ff + HALF_LSB;
      shifted = rounded >>> ROUND_SHIFT;
      if (bl2_zero_ff) begin
         result = '0;
      end else if (shifted > OUT_MAX) begin
         result = OUT_BITS'(OUT_MAX);
      end else if (shifted < OUT_MIN) begin
         result = OUT_BITS'(OUT_MIN);
      end else begin
         result = OUT_BITS'(shifted);
      end
   end

   // Response queue; room is reserved when a query starts.
   always_comb begin
      ow_ptr_in = ow_ptr_ff;
      or_ptr_in = or_ptr_ff;
      ocount_in = ocount_ff;
      if (bl2_valid_ff) begin
         ow_ptr_in = (32'(ow_ptr_ff) == OUT_DEPTH - 1) ? '0 : ow_ptr_ff + OPTR_BITS'(1);
      end
      if (rsp_xfer) begin
         or_ptr_in = (32'(or_ptr_ff) == OUT_DEPTH - 1) ? '0 : or_ptr_ff + OPTR_BITS'(1);
      end
      if (bl2_valid_ff && !rsp_xfer) begin
         ocount_in = ocount_ff + OCNT_BITS'(1);
      end else if (rsp_xfer && !bl2_valid_ff) begin
         ocount_in = ocount_ff - OCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ow_ptr_ff <= '0;
         or_ptr_ff <= '0;
         ocount_ff <= '0;
      end else begin
         ow_ptr_ff <= ow_ptr_in;
         or_ptr_ff <= or_ptr_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bl2_valid_ff) begin
         ofifo_ff[ow_ptr_ff] <= result;
      end
   end

   assign rsp_if.valid        = (ocount_ff != '0);
   assign rsp_if.elevation_q8 = ofifo_ff[or_ptr_ff];

`ifndef SYNTHESIS
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= OCNT_BITS'(OUT_DEPTH))
      else $error("More queries in flight than response slots.");

   a_rsp_queue_room: assert property (@(posedge clock) disable iff (reset)
      bl2_valid_ff |-> (ocount_ff < OCNT_BITS'(OUT_DEPTH) || rsp_xfer))
      else $error("Blend result arrived with the response queue full.");

   a_rsp_within_credit: assert property (@(posedge clock) disable iff (reset)
      ocount_ff <= inflight_ff)
      else $error("Response queue holds more entries than queries in flight.");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && phase_ff == CORNER_11) |=>
         (!busy_ff && rd_valid_ff && rd_sel_ff == CORNER_11))
      else $error("Sequencer did not finish on the last corner read.");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_bilinear_grid_elevation.sv -----
// Self-checking testbench for bilinear_grid_elevation: drives cell writes and elevation
// queries, predicts each interpolated elevation and compares it with the response channel.
// Depends on bge_pkg, the channel interfaces in bge_if.sv and the block's RTL.

module tb_bilinear_grid_elevation;
   timeunit 1ns;
   timeprecision 1ps;

   import bge_pkg::*;

   // One request as the driver offers it.
   typedef struct {
      logic                           cmd;
      logic        [CELL_IN_BITS-1:0] cell_col;
      logic        [CELL_IN_BITS-1:0] cell_row;
      logic signed [ELEV_IN_BITS-1:0] cell_elev;
      logic signed [POS_BITS-1:0]     east_ft;
      logic signed [POS_BITS-1:0]     northing_ft;
   } grid_op_type;

   // The four neighbor cells of a query and its fractions.
   typedef struct {
      int     x0;
      int     x1;
      int     r0;
      int     r1;
      longint tx;
      longint ty;
   } cell_quad_type;

   logic clock;
   logic reset;

   bge_req_if req_if ();
   bge_rsp_if rsp_if ();
   bge_csr_if csr_if ();

   bilinear_grid_elevation u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Register shadow, updated when a register write transfers.
   logic                    cfg_has_elevation = 1'b0;
   logic [DIM_CFG_BITS-1:0] cfg_grid_width    = 9'd256;
   logic [DIM_CFG_BITS-1:0] cfg_grid_height   = 9'd256;
   logic [SCALE_BITS-1:0]   cfg_cells_per_ft  = '0;

   // Grid contents as written through the block, and the cells the stimulus has covered.
   elev_type grid_model [0:MAX_WIDTH*MAX_HEIGHT-1];
   bit       cell_planned [0:MAX_WIDTH*MAX_HEIGHT-1];

   grid_op_type                pending_ops[$];
   logic signed [OUT_BITS-1:0] elev_expected[$];

   logic req_taken;
   logic rsp_hold;
   int   idle_pct = 12;
   int   mismatch_count;
   int   write_count;
   int   query_count;
   int   result_count;
   int   setting_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_bilinear_grid_elevation: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int dim_in_use(input logic [DIM_CFG_BITS-1:0] v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Position in feet to a Q.16 cell coordinate, clamped to the grid.
   function automatic logic [63:0] scaled_coord(input logic signed [POS_BITS-1:0] pos,
                                                input int dim);
      logic [63:0] product;
      logic [63:0] limit;
      if (pos < 0) return 64'd0;
      product = {32'd0, pos} * {32'd0, cfg_cells_per_ft};
      product = product >> FRAC_BITS;
      limit   = 64'(dim - 1) << FRAC_BITS;
      return (product > limit) ? limit : product;
   endfunction

   function automatic cell_quad_type locate_quad(input logic signed [POS_BITS-1:0] east,
                                                 input logic signed [POS_BITS-1:0] north);
      cell_quad_type q;
      int            w;
      int            h;
      int            y0;
      int            y1;
      logic [63:0]   cx;
      logic [63:0]   cy;
      w    = dim_in_use(cfg_grid_width, MAX_WIDTH);
      h    = dim_in_use(cfg_grid_height, MAX_HEIGHT);
      cx   = scaled_coord(east, w);
      cy   = scaled_coord(north, h);
      q.x0 = int'(cx >> FRAC_BITS);
      y0   = int'(cy >> FRAC_BITS);
      q.tx = cx[FRAC_BITS-1:0];
      q.ty = cy[FRAC_BITS-1:0];
      q.x1 = (q.x0 + 1 < w) ? q.x0 + 1 : w - 1;
      y1   = (y0 + 1 < h) ? y0 + 1 : h - 1;
      // Stored rows count from the north edge.
      q.r0 = h - 1 - y0;
      q.r1 = h - 1 - y1;
      return q;
   endfunction

   function automatic logic signed [OUT_BITS-1:0] predict_elevation(input grid_op_type op);
      cell_quad_type q;
      longint        e00;
      longint        e10;
      longint        e01;
      longint        e11;
      longint        e0;
      longint        e1;
      longint        e;
      longint        rounded;
      if (!cfg_has_elevation || cfg_cells_per_ft == 0) return '0;
      q   = locate_quad(op.east_ft, op.northing_ft);
      e00 = grid_model[q.r0*MAX_WIDTH + q.x0];
      e10 = grid_model[q.r0*MAX_WIDTH + q.x1];
      e01 = grid_model[q.r1*MAX_WIDTH + q.x0];
      e11 = grid_model[q.r1*MAX_WIDTH + q.x1];
      // Blend along x in Q.16, then along y in Q.32.
      e0 = e00 * 65536 + (e10 - e00) * q.tx;
      e1 = e01 * 65536 + (e11 - e01) * q.tx;
      e  = e0 * 65536 + (e1 - e0) * q.ty;
      // Round half up to Q.8 and saturate to the output width.
      rounded = (e + 64'sd8388608) >>> 24;
      if (rounded > 8388607) rounded = 8388607;
      else if (rounded < -8388608) rounded = -8388608;
      return rounded[OUT_BITS-1:0];
   endfunction

   // Request transfers update the grid or queue the expected elevation.
   always @(posedge clock) begin : track_requests
      grid_op_type op;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            op.cmd         = req_if.cmd;
            op.cell_col    = req_if.cell_col;
            op.cell_row    = req_if.cell_row;
            op.cell_elev   = req_if.cell_elev;
            op.east_ft     = req_if.east_ft;
            op.northing_ft = req_if.northing_ft;
            if (op.cmd == CMD_WRITE) begin
               grid_model[op.cell_row*MAX_WIDTH + op.cell_col] = op.cell_elev;
               write_count++;
            end else begin
               elev_expected.push_back(predict_elevation(op));
               query_count++;
            end
         end
      end
   end

   // Each response transfer is checked against the oldest expected elevation.
   always @(posedge clock) begin : check_results
      logic signed [OUT_BITS-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (elev_expected.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %0d", $time,
                     rsp_if.elevation_q8);
            mismatch_count++;
         end else begin
            want = elev_expected.pop_front();
            result_count++;
            if (rsp_if.elevation_q8 !== want) begin
               $display("%0t: elevation_q8 mismatch: expected %0d, actual %0d", $time,
                        want, rsp_if.elevation_q8);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Request driver: holds an offered item until it transfers, otherwise takes the next.
   always @(negedge clock) begin : drive_requests
      grid_op_type op;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            op = pending_ops.pop_front();
            req_if.valid       <= 1'b1;
            req_if.cmd         <= op.cmd;
            req_if.cell_col    <= op.cell_col;
            req_if.cell_row    <= op.cell_row;
            req_if.cell_elev   <= op.cell_elev;
            req_if.east_ft     <= op.east_ft;
            req_if.northing_ft <= op.northing_ft;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !rsp_hold && ($urandom_range(0, 99) >= idle_pct);
   end

   // The response side stops for a long stretch once while queries keep coming.
   initial begin : receiver_hold
      rsp_hold = 1'b0;
      do @(posedge clock); while (!(query_count >= 150 && pending_ops.size() > 40));
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic program_register(input logic [CSR_INDEX_BITS-1:0] index,
                                   input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      case (index)
         CSR_HAS_ELEVATION: cfg_has_elevation = value[0];
         CSR_GRID_WIDTH:    cfg_grid_width    = value[DIM_CFG_BITS-1:0];
         CSR_GRID_HEIGHT:   cfg_grid_height   = value[DIM_CFG_BITS-1:0];
         CSR_CELLS_PER_FT:  cfg_cells_per_ft  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_grid(input logic has_elev, input logic [DIM_CFG_BITS-1:0] w,
                               input logic [DIM_CFG_BITS-1:0] h,
                               input logic [SCALE_BITS-1:0] cpf);
      program_register(CSR_HAS_ELEVATION, 32'(has_elev));
      program_register(CSR_GRID_WIDTH, 32'(w));
      program_register(CSR_GRID_HEIGHT, 32'(h));
      program_register(CSR_CELLS_PER_FT, cpf);
      setting_count++;
   endtask

   // Waits until every item has transferred and every result has come back.
   task automatic wait_until_idle();
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_if.valid || elev_expected.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   function automatic grid_op_type random_op();
      grid_op_type op;
      op.cmd         = 1'($urandom);
      op.cell_col    = 8'($urandom);
      op.cell_row    = 8'($urandom);
      op.cell_elev   = 16'($urandom);
      op.east_ft     = $urandom;
      op.northing_ft = $urandom;
      return op;
   endfunction

   function automatic logic signed [ELEV_IN_BITS-1:0] pick_elev();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void plan_write(input logic [CELL_IN_BITS-1:0] col,
                                      input logic [CELL_IN_BITS-1:0] row,
                                      input logic signed [ELEV_IN_BITS-1:0] elev);
      grid_op_type op;
      op           = random_op();
      op.cmd       = CMD_WRITE;
      op.cell_col  = col;
      op.cell_row  = row;
      op.cell_elev = elev;
      pending_ops.push_back(op);
      cell_planned[row*MAX_WIDTH + col] = 1'b1;
   endfunction

   // A query is preceded by writes to any of its cells that hold no data yet.
   function automatic void plan_query(input logic signed [POS_BITS-1:0] east,
                                      input logic signed [POS_BITS-1:0] north);
      grid_op_type   op;
      cell_quad_type q;
      int            cols[4];
      int            rows[4];
      q    = locate_quad(east, north);
      cols = '{q.x0, q.x1, q.x0, q.x1};
      rows = '{q.r0, q.r0, q.r1, q.r1};
      foreach (cols[i])
         if (!cell_planned[rows[i]*MAX_WIDTH + cols[i]])
            plan_write(cols[i], rows[i], pick_elev());
      op             = random_op();
      op.cmd         = CMD_QUERY;
      op.east_ft     = east;
      op.northing_ft = north;
      pending_ops.push_back(op);
   endfunction

   // Positions mostly land inside the grid; some fall before it, past it or anywhere.
   function automatic logic signed [POS_BITS-1:0] pick_pos(input int dim, input int span);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return -int'($urandom_range(1, 5000));
         2: return dim * span + int'($urandom_range(0, 4 * span));
         default: return $urandom_range(0, dim * span);
      endcase
   endfunction

   function automatic logic [DIM_CFG_BITS-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'($urandom_range(257, 511));
         3: return 9'd256;
         default: return 9'($urandom_range(2, 256));
      endcase
   endfunction

   initial begin : stimulus
      logic [SCALE_BITS-1:0]   cpf;
      logic [DIM_CFG_BITS-1:0] w;
      logic [DIM_CFG_BITS-1:0] h;
      logic                    has_elev;
      longint                  span64;
      int                      span;
      int                      wd;
      int                      hd;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_WRITE;
      {req_if.cell_col, req_if.cell_row, req_if.cell_elev} = '0;
      {req_if.east_ft, req_if.northing_ft} = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_HAS_ELEVATION;
      csr_if.data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers at their reset values: no elevation data, every query reads zero.
      plan_query(100, 100);
      plan_query(-5, 7);
      wait_until_idle();

      // Elevation enabled but a zero scale still reads zero.
      program_register(CSR_HAS_ELEVATION, 32'd1);
      plan_query(1234, 99);
      plan_query(32'sh7FFF_FFFF, 0);
      wait_until_idle();

      // Full grid at the largest scale: corners, clamped positions and a wide swing.
      program_grid(1'b1, 9'd256, 9'd256, 32'hFFFF_FFFF);
      plan_write(0, 0, 16'sh7FFF);
      plan_write(255, 255, 16'sh8000);
      plan_write(255, 0, 16'shFFFF);
      plan_write(0, 255, 16'sh0000);
      plan_query(0, 0);
      plan_query(-1, 32'sh8000_0000);
      plan_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      plan_write(9, 246, 16'sh7FFF);
      plan_write(10, 246, 16'sh8000);
      plan_write(9, 245, 16'sh8000);
      plan_write(10, 245, 16'sh7FFF);
      plan_query(10, 10);
      plan_query(1000, 50);
      wait_until_idle();

      // One-cell grid, then a zero size that acts as one.
      program_grid(1'b1, 9'd1, 9'd1, 32'h2492_4924);
      repeat (4) plan_query(pick_pos(1, 8), pick_pos(1, 8));
      wait_until_idle();
      program_grid(1'b1, 9'd0, 9'd0, 32'h2492_4924);
      repeat (3) plan_query(pick_pos(1, 8), pick_pos(1, 8));
      wait_until_idle();

      // Oversized dimensions saturate; the smallest scale barely moves off the corner.
      program_grid(1'b1, 9'd511, 9'd257, 32'd1);
      repeat (3) plan_query($urandom, $urandom);
      plan_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      wait_until_idle();

      // Random settings, each with a burst of about 200 writes and queries.
      for (int phase = 0; phase < 9; phase++) begin
         has_elev = ($urandom_range(0, 9) != 0);
         w = pick_dim();
         h = pick_dim();
         case ($urandom_range(0, 7))
            0: cpf = 32'hFFFF_FFFF;
            1: cpf = $urandom;
            2: cpf = 32'd1;
            3: cpf = (phase == 5) ? 32'd0 : 32'($urandom_range(1, 999));
            default: cpf = 32'(64'h1_0000_0000 / $urandom_range(2, 4000)) ^ $urandom_range(0, 255);
         endcase
         span64 = (cpf == 0) ? 1000 : 64'h1_0000_0000 / cpf + 1;
         span   = (span64 > 4_000_000) ? 4_000_000 : int'(span64);
         program_grid(has_elev, w, h, cpf);
         wd = dim_in_use(w, MAX_WIDTH);
         hd = dim_in_use(h, MAX_HEIGHT);
         idle_pct = (phase == 2) ? 0 : 12;
         while (pending_ops.size() < 200) begin
            if ($urandom_range(0, 4) == 0)
               plan_write(8'($urandom), 8'($urandom), pick_elev());
            else
               plan_query(pick_pos(wd, span), pick_pos(hd, span));
         end
         wait_until_idle();
      end

      $display("Run covered %0d cell writes and %0d queries over %0d register settings;",
               write_count, query_count, setting_count);
      $display("%0d elevations checked, %0d mismatches.", result_count, mismatch_count);
      if (mismatch_count == 0 && elev_expected.size() == 0) begin
         $display("tb_bilinear_grid_elevation: PASS");
      end else begin
         $display("tb_bilinear_grid_elevation: FAIL");
      end
      $finish;
   end

endmodule
